@@ src/cpot_pkg.sv @@
// package for the convex polygon overlap test unit
`default_nettype none
package cpot_pkg;
   localparam int unsigned CoordWidth  = 16;
   localparam int unsigned VertexWidth = 2 * CoordWidth;
   localparam int unsigned NormWidth   = CoordWidth + 1;
   localparam int unsigned ProdWidth   = CoordWidth + NormWidth;
   localparam int unsigned ProjWidth   = ProdWidth + 1;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [NormWidth-1:0]  norm_type;
   typedef logic signed [ProjWidth-1:0]  proj_type;

   localparam logic PolyA = 1'b0;
   localparam logic PolyB = 1'b1;
endpackage
`default_nettype wire

@@ src/cpot_ram.sv @@
// generic single-port-write ram with registered read
`default_nettype none
module cpot_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ src/convex_polygon_overlap_test_unit.sv @@
// separating-axis overlap test for two convex polygons held in vertex rams
// a vertex without end_of_pair goes to its ram (if not full); busy stays low
// a closing request keeps busy high until an axis separates or all axes are done
// per axis: EDGE_* form the normal, PROJ projects a vertex a cycle, CHECK compares
// rsp_valid pulses in the same cycle busy drops; the receiver cannot stall
// reset clears counts, overflow flag and sequencer; ram contents stay undefined
`default_nettype none
module convex_polygon_overlap_test_unit
   import cpot_pkg::*;
#(
   parameter int unsigned MAX_VERTICES = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire logic                  req_polygon_select,
   input  wire logic signed [15:0]    req_vertex_x,
   input  wire logic signed [15:0]    req_vertex_y,
   input  wire logic                  req_end_of_pair,
   output      logic                  rsp_valid,
   output      logic                  rsp_overlap,
   output      logic                  rsp_bad_input
);
   localparam int unsigned AddrWidth  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int unsigned CountWidth = $clog2(MAX_VERTICES + 1);
   localparam int unsigned RamDepth   = 1 << AddrWidth;

   typedef enum logic [2:0] {
      IDLE, EDGE_RD0, EDGE_RD1, EDGE_CAP, PROJ, CHECK, DONE
   } state_type;

   state_type                 state_ff;
   logic [CountWidth-1:0]     cnt_a_ff, cnt_b_ff;
   logic                      ovf_ff;
   logic                      bad_ff, hit_ff;
   logic                      axis_poly_ff;
   logic [AddrWidth-1:0]      edge_ff;
   logic                      proj_poly_ff;
   logic [AddrWidth-1:0]      vtx_ff;
   logic                      data_ok_ff;
   logic                      data_poly_ff;
   logic                      first_a_ff, first_b_ff;
   coord_type                 ex0_ff, ey0_ff;
   norm_type                  nx_ff, ny_ff;
   proj_type                  alo_ff, ahi_ff, blo_ff, bhi_ff;

   logic                      accept;
   logic                      wr_a, wr_b;
   logic [AddrWidth-1:0]      wr_addr_a, wr_addr_b;
   logic [AddrWidth-1:0]      rd_addr_a, rd_addr_b;
   logic [VertexWidth-1:0]    rd_a, rd_b, rd_sel;
   logic [VertexWidth-1:0]    wr_data;
   logic [CountWidth-1:0]     cnt_a_in, cnt_b_in;
   logic                      ovf_in;
   logic [CountWidth-1:0]     axis_cnt, proj_cnt;
   logic [AddrWidth-1:0]      edge_next, vtx_last;
   coord_type                 rx, ry;
   logic signed [ProdWidth-1:0] px, py;
   proj_type                  p;

   assign accept  = start && !busy;
   assign wr_data = {req_vertex_y, req_vertex_x};
   assign wr_a    = accept && req_polygon_select == PolyA && cnt_a_ff < CountWidth'(MAX_VERTICES);
   assign wr_b    = accept && req_polygon_select == PolyB && cnt_b_ff < CountWidth'(MAX_VERTICES);
   assign wr_addr_a = cnt_a_ff[AddrWidth-1:0];
   assign wr_addr_b = cnt_b_ff[AddrWidth-1:0];

   assign cnt_a_in = wr_a ? cnt_a_ff + 1'b1 : cnt_a_ff;
   assign cnt_b_in = wr_b ? cnt_b_ff + 1'b1 : cnt_b_ff;
   assign ovf_in   = ovf_ff || (accept && !wr_a && !wr_b);

   assign axis_cnt  = axis_poly_ff ? cnt_b_ff : cnt_a_ff;
   assign proj_cnt  = proj_poly_ff ? cnt_b_ff : cnt_a_ff;
   assign vtx_last  = AddrWidth'(proj_cnt - 1'b1);
   assign edge_next = (CountWidth'(edge_ff) + 1'b1 < axis_cnt) ? edge_ff + 1'b1 : '0;

   always_comb begin
      rd_addr_a = vtx_ff;
      rd_addr_b = vtx_ff;
      unique case (state_ff)
         EDGE_RD0: begin
            rd_addr_a = edge_ff;
            rd_addr_b = edge_ff;
         end
         EDGE_RD1: begin
            rd_addr_a = edge_next;
            rd_addr_b = edge_next;
         end
         default: begin
         end
      endcase
   end

   cpot_ram #(.Width(VertexWidth), .Depth(RamDepth)) u_ram_a (
      .clock(clock), .wr_en(wr_a), .wr_addr(wr_addr_a), .wr_data(wr_data),
      .rd_addr(rd_addr_a), .rd_data(rd_a)
   );
   cpot_ram #(.Width(VertexWidth), .Depth(RamDepth)) u_ram_b (
      .clock(clock), .wr_en(wr_b), .wr_addr(wr_addr_b), .wr_data(wr_data),
      .rd_addr(rd_addr_b), .rd_data(rd_b)
   );

   always_comb begin
      unique case (state_ff)
         EDGE_RD1, EDGE_CAP: rd_sel = axis_poly_ff ? rd_b : rd_a;
         default:            rd_sel = data_poly_ff ? rd_b : rd_a;
      endcase
   end
   assign rx = rd_sel[CoordWidth-1:0];
   assign ry = rd_sel[VertexWidth-1:CoordWidth];
   assign px = rx * nx_ff;
   assign py = ry * ny_ff;
   assign p  = ProjWidth'(px) + ProjWidth'(py);

   assign busy = state_ff != IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         cnt_a_ff   <= '0;
         cnt_b_ff   <= '0;
         ovf_ff     <= 1'b0;
         rsp_valid  <= 1'b0;
         data_ok_ff <= 1'b0;
      end else begin
         rsp_valid  <= 1'b0;
         data_ok_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  cnt_a_ff <= cnt_a_in;
                  cnt_b_ff <= cnt_b_in;
                  ovf_ff   <= ovf_in;
                  if (req_end_of_pair) begin
                     bad_ff       <= ovf_in || cnt_a_in == '0 || cnt_b_in == '0;
                     hit_ff       <= 1'b1;
                     axis_poly_ff <= PolyA;
                     edge_ff      <= '0;
                     state_ff     <= (ovf_in || cnt_a_in == '0 || cnt_b_in == '0)
                                     ? DONE : EDGE_RD0;
                  end
               end
            end
            EDGE_RD0: state_ff <= EDGE_RD1;
            EDGE_RD1: begin
               ex0_ff   <= rx;
               ey0_ff   <= ry;
               state_ff <= EDGE_CAP;
            end
            EDGE_CAP: begin
               nx_ff        <= NormWidth'(ey0_ff) - NormWidth'(ry);
               ny_ff        <= NormWidth'(rx) - NormWidth'(ex0_ff);
               proj_poly_ff <= PolyA;
               vtx_ff       <= '0;
               first_a_ff   <= 1'b1;
               first_b_ff   <= 1'b1;
               state_ff     <= PROJ;
            end
            PROJ: begin
               // issue reads, fold in the one returned last cycle
               if (data_ok_ff) begin
                  if (!data_poly_ff) begin
                     if (first_a_ff || p < alo_ff) alo_ff <= p;
                     if (first_a_ff || p > ahi_ff) ahi_ff <= p;
                     first_a_ff <= 1'b0;
                  end else begin
                     if (first_b_ff || p < blo_ff) blo_ff <= p;
                     if (first_b_ff || p > bhi_ff) bhi_ff <= p;
                     first_b_ff <= 1'b0;
                  end
               end
               if (proj_poly_ff == PolyB && vtx_ff == vtx_last && data_ok_ff
                   && data_poly_ff == PolyB && proj_cnt == CountWidth'(1)) begin
                  state_ff <= CHECK;
               end else if (!(data_ok_ff && data_poly_ff == PolyB
                              && vtx_ff == '0 && proj_poly_ff == PolyB
                              && !first_b_ff)) begin
                  data_ok_ff   <= 1'b1;
                  data_poly_ff <= proj_poly_ff;
                  if (vtx_ff == vtx_last) begin
                     if (proj_poly_ff == PolyA) begin
                        proj_poly_ff <= PolyB;
                        vtx_ff       <= '0;
                     end else begin
                        data_ok_ff <= 1'b1;
                        state_ff   <= CHECK;
                     end
                  end else begin
                     vtx_ff <= vtx_ff + 1'b1;
                  end
               end
            end
            CHECK: begin
               if (data_ok_ff) begin
                  // last vertex of b arrives here
                  if (first_b_ff || p < blo_ff) blo_ff <= p;
                  if (first_b_ff || p > bhi_ff) bhi_ff <= p;
                  first_b_ff <= 1'b0;
               end else begin
                  if (ahi_ff < blo_ff || bhi_ff < alo_ff) hit_ff <= 1'b0;
                  if (ahi_ff < blo_ff || bhi_ff < alo_ff) begin
                     state_ff <= DONE;
                  end else if (CountWidth'(edge_ff) + 1'b1 < axis_cnt) begin
                     edge_ff  <= edge_ff + 1'b1;
                     state_ff <= EDGE_RD0;
                  end else if (axis_poly_ff == PolyA) begin
                     axis_poly_ff <= PolyB;
                     edge_ff      <= '0;
                     state_ff     <= EDGE_RD0;
                  end else begin
                     state_ff <= DONE;
                  end
               end
            end
            DONE: begin
               rsp_valid     <= 1'b1;
               rsp_overlap   <= hit_ff && !bad_ff;
               rsp_bad_input <= bad_ff;
               cnt_a_ff      <= '0;
               cnt_b_ff      <= '0;
               ovf_ff        <= 1'b0;
               state_ff      <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
